[src/ssc_pkg.sv]
// Shared types and constants of the spaced sample collector.
package ssc_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQUARE_W    = 2 * COORD_W;
  localparam int ENTRY_W     = 3 * COORD_W;
  localparam int CODE_W      = 3;
  localparam int COUNT_W     = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int MIN_DIST_W  = 34;

  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RESET = 34'd30976;

  localparam logic [CFG_INDEX_W-1:0] REG_COLLECT_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DIST       = 2'd1;

  typedef enum logic [CODE_W-1:0] {
    CODE_STORED    = 3'd0,
    CODE_TOO_CLOSE = 3'd1,
    CODE_FULL      = 3'd2,
    CODE_DISABLED  = 3'd3,
    CODE_CLEARED   = 3'd4
  } code_t;

  typedef enum logic [1:0] {
    KIND_OFFER,
    KIND_CLEAR,
    KIND_DISABLED
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } cmd_t;

endpackage

[src/ssc_front.sv]
// Front end: accepts items, classifies them and holds them in a two-entry queue.
module ssc_front
  import ssc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      operation,
  input  logic signed [COORD_W-1:0] mag_x,
  input  logic signed [COORD_W-1:0] mag_y,
  input  logic signed [COORD_W-1:0] mag_z,
  input  logic                      collect_enable,
  output logic                      cmd_valid,
  output cmd_t                      cmd,
  input  logic                      cmd_take
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;
  cmd_t       incoming;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = queue[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  // Enable is sampled at acceptance; the user must change it only while the block is idle, which is not enforced.
  always_comb begin
    incoming.x = mag_x;
    incoming.y = mag_y;
    incoming.z = mag_z;
    if (operation) begin
      incoming.kind = KIND_CLEAR;
    end else if (!collect_enable) begin
      incoming.kind = KIND_DISABLED;
    end else begin
      incoming.kind = KIND_OFFER;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[src/ssc_back.sv]
// Back end: sample store, spacing scan pipeline and result register.
module ssc_back
  import ssc_pkg::*;
#(
  parameter int STORE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_take,
  input  logic [MIN_DIST_W-1:0] min_distance_squared,
  output logic                  empty,
  input  logic                  pop,
  output logic [CODE_W-1:0]     result_code,
  output logic [COUNT_W-1:0]    stored_count,
  output logic                  store_full
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];

  state_t             state, state_next;
  cmd_t               cur;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   issue, issue_next;
  logic               start;
  logic               rd_en;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic               p1_valid, p2_valid, p3_valid;
  logic signed [DIFF_W-1:0]   d_x, d_y, d_z;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;
  logic [SQUARE_W-1:0] sq_x, sq_y, sq_z;
  logic [MIN_DIST_W-1:0] dist_sum;
  logic               close;
  logic               res_valid;
  logic               res_load;
  code_t              res_code_next;
  code_t              res_code;

  assign empty        = !res_valid;
  assign result_code  = res_code;
  assign rd_en        = (state == ST_SCAN) && (issue < count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[count[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store_mem[issue[IDX_W-1:0]];
    end
  end

  // Distance pipeline: read, per-axis difference, squares, then sum and compare.
  assign prod_x   = d_x * d_x;
  assign prod_y   = d_y * d_y;
  assign prod_z   = d_z * d_z;
  assign dist_sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};

  always_ff @(posedge clk) begin
    d_x  <= {cur.x[COORD_W-1], cur.x} - {rd_data[3*COORD_W-1], rd_data[3*COORD_W-1:2*COORD_W]};
    d_y  <= {cur.y[COORD_W-1], cur.y} - {rd_data[2*COORD_W-1], rd_data[2*COORD_W-1:COORD_W]};
    d_z  <= {cur.z[COORD_W-1], cur.z} - {rd_data[COORD_W-1], rd_data[COORD_W-1:0]};
    sq_x <= prod_x[SQUARE_W-1:0];
    sq_y <= prod_y[SQUARE_W-1:0];
    sq_z <= prod_z[SQUARE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
  end

  always_comb begin
    state_next    = state;
    cmd_take      = 1'b0;
    count_next    = count;
    issue_next    = issue;
    start         = 1'b0;
    wr_en         = 1'b0;
    wr_data       = {cur.x, cur.y, cur.z};
    res_load      = 1'b0;
    res_code_next = CODE_STORED;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && (!res_valid || pop)) begin
          cmd_take = 1'b1;
          wr_data  = {cmd.x, cmd.y, cmd.z};
          case (cmd.kind)
            KIND_CLEAR: begin
              count_next    = '0;
              res_load      = 1'b1;
              res_code_next = CODE_CLEARED;
            end
            KIND_DISABLED: begin
              res_load      = 1'b1;
              res_code_next = CODE_DISABLED;
            end
            default: begin
              if (count >= DEPTH_CNT) begin
                res_load      = 1'b1;
                res_code_next = CODE_FULL;
              end else if (count == '0) begin
                // An empty store accepts any sample without a scan.
                wr_en         = 1'b1;
                count_next    = count + CNT_W'(1);
                res_load      = 1'b1;
                res_code_next = CODE_STORED;
              end else begin
                start      = 1'b1;
                issue_next = '0;
                state_next = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_next = issue + CNT_W'(1);
        end
        // The verdict waits until every issued entry has left the pipeline.
        if ((issue == count) && !p1_valid && !p2_valid && !p3_valid) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
          if (close) begin
            res_code_next = CODE_TOO_CLOSE;
          end else begin
            wr_en         = 1'b1;
            count_next    = count + CNT_W'(1);
            res_code_next = CODE_STORED;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      issue     <= '0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      close     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      issue    <= issue_next;
      p1_valid <= rd_en;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      if (start) begin
        close <= 1'b0;
      end else if (p3_valid && (dist_sum < min_distance_squared)) begin
        close <= 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_code     <= res_code_next;
      stored_count <= COUNT_W'(count_next);
      store_full   <= (count_next == DEPTH_CNT);
    end
  end

endmodule

[src/spaced_sample_collector.sv]
// Spaced sample collector top level: configuration registers, front and back ends.
// A clear, a refused sample or a sample into an empty store is settled without a scan;
// a sample checked against stored entries waits for the scan of every one of them.
// A scanned sample holds off the next item until its verdict, as the spacing scan reads
// the store one entry a cycle; other items go at one per cycle while results are popped.
// Reset is synchronous; it empties the store by zeroing the count, with no clearing pass.
module spaced_sample_collector
  import ssc_pkg::*;
#(
  parameter int STORE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      operation,
  input  logic signed [COORD_W-1:0] mag_x,
  input  logic signed [COORD_W-1:0] mag_y,
  input  logic signed [COORD_W-1:0] mag_z,
  output logic                      empty,
  input  logic                      pop,
  output logic [CODE_W-1:0]         result_code,
  output logic [COUNT_W-1:0]        stored_count,
  output logic                      store_full,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [MIN_DIST_W-1:0]     cfg_data
);

  logic                  collect_enable;
  logic [MIN_DIST_W-1:0] min_distance_squared;
  logic                  cmd_valid;
  cmd_t                  cmd;
  logic                  cmd_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      collect_enable       <= 1'b0;
      min_distance_squared <= MIN_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLLECT_ENABLE: collect_enable       <= cfg_data[0];
        REG_MIN_DIST:       min_distance_squared <= cfg_data;
        default:            ;
      endcase
    end
  end

  ssc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .operation      (operation),
    .mag_x          (mag_x),
    .mag_y          (mag_y),
    .mag_z          (mag_z),
    .collect_enable (collect_enable),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take)
  );

  ssc_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_take             (cmd_take),
    .min_distance_squared (min_distance_squared),
    .empty                (empty),
    .pop                  (pop),
    .result_code          (result_code),
    .stored_count         (stored_count),
    .store_full           (store_full)
  );

endmodule

[test/tb_spaced_sample_collector.sv]
// Testbench for the spaced sample collector: directed and random samples, clears and spacing settings.
module tb_spaced_sample_collector;
  timeunit 1ns;
  timeprecision 1ps;
  import ssc_pkg::*;

  localparam int DEPTH = 256;
  localparam int QUIET_LIMIT = 5000;
  localparam int PRINT_LIMIT = 200;
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  // Three times the square of the widest axis span: the two opposite corners sit exactly here.
  localparam logic [MIN_DIST_W-1:0] CORNER_SPAN_SQ = 34'd12884508675;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -16'sd32768;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sd32767;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    code_t              code;
    logic [COUNT_W-1:0] count;
    logic               full;
  } outcome_t;

  class spacing_scoreboard;
    logic signed [COORD_W-1:0] held_x [DEPTH];
    logic signed [COORD_W-1:0] held_y [DEPTH];
    logic signed [COORD_W-1:0] held_z [DEPTH];
    int unsigned held_count;
    logic enable;
    logic [MIN_DIST_W-1:0] min_dist;
    outcome_t pending[$];
    int mismatches;

    function new();
      held_count = 0;
      enable = 1'b0;
      min_dist = MIN_DIST_RESET;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [MIN_DIST_W-1:0] data);
      if (idx == REG_COLLECT_ENABLE) begin
        enable = data[0];
      end else if (idx == REG_MIN_DIST) begin
        min_dist = data;
      end
    endfunction

    function bit spaced_from_store(logic signed [COORD_W-1:0] x, y, z);
      longint dx, dy, dz;
      for (int i = 0; i < held_count; i++) begin
        dx = longint'(x) - longint'(held_x[i]);
        dy = longint'(y) - longint'(held_y[i]);
        dz = longint'(z) - longint'(held_z[i]);
        if (dx * dx + dy * dy + dz * dz < longint'(min_dist)) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Works out the outcome of one accepted item and queues it.
    function void note_item(logic op, logic signed [COORD_W-1:0] x, y, z);
      outcome_t o;
      if (op == OP_CLEAR) begin
        held_count = 0;
        o.code = CODE_CLEARED;
      end else if (!enable) begin
        o.code = CODE_DISABLED;
      end else if (held_count >= DEPTH) begin
        o.code = CODE_FULL;
      end else if (spaced_from_store(x, y, z)) begin
        held_x[held_count] = x;
        held_y[held_count] = y;
        held_z[held_count] = z;
        held_count++;
        o.code = CODE_STORED;
      end else begin
        o.code = CODE_TOO_CLOSE;
      end
      o.count = held_count[COUNT_W-1:0];
      o.full = (held_count >= DEPTH);
      pending.push_back(o);
    endfunction

    task report_mismatch(string what);
      // Printing is capped so that a badly broken block cannot flood the log.
      if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [CODE_W-1:0] code, logic [COUNT_W-1:0] count, logic full);
      outcome_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result code %0d count %0d", code, count));
        return;
      end
      want = pending.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("result_code %0d, expected %0d", code, want.code));
      if (count !== want.count)
        report_mismatch($sformatf("stored_count %0d, expected %0d", count, want.count));
      if (full !== want.full)
        report_mismatch($sformatf("store_full %0b, expected %0b", full, want.full));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic operation = OP_OFFER;
  logic signed [COORD_W-1:0] mag_x = '0;
  logic signed [COORD_W-1:0] mag_y = '0;
  logic signed [COORD_W-1:0] mag_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CODE_W-1:0] result_code;
  logic [COUNT_W-1:0] stored_count;
  logic store_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_COLLECT_ENABLE;
  logic [MIN_DIST_W-1:0] cfg_data = '0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_req = 0;
  int recv_hold_left = 0;
  int quiet_cycles = 0;
  spacing_scoreboard sb;

  spaced_sample_collector #(.STORE_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .operation(operation),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
    .empty(empty), .pop(pop),
    .result_code(result_code), .stored_count(stored_count), .store_full(store_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_item(operation, mag_x, mag_y, mag_z);
  end

  // Result side: checks each transfer, then decides whether to pop on the next edge.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(result_code, stored_count, store_full);
      if (recv_hold_req > 0) begin
        recv_hold_left = recv_hold_req;
        recv_hold_req = 0;
      end
      if (recv_hold_left > 0) begin
        pop <= 1'b0;
        recv_hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** spaced_sample_collector: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic op, input logic signed [COORD_W-1:0] x, y, z);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    operation <= op;
    mag_x <= x;
    mag_y <= y;
    mag_z <= z;
    do @(posedge clk); while (full);
  endtask

  task automatic clear_store();
    send_item(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // Stops offering and waits until every queued outcome has been checked.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [MIN_DIST_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 48;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        recv_stall_pct = 48;
      end
      default: begin
        sender_idle_pct = 18;
        recv_stall_pct = 18;
      end
    endcase
  endtask

  function automatic logic signed [COORD_W-1:0] nudge(logic signed [COORD_W-1:0] base,
                                                        int radius);
    int v;
    v = int'(base) + int'($urandom_range(2 * radius)) - radius;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return COORD_W'(v);
  endfunction

  // Most offers land near a sample already held, so both sides of the spacing test get hit.
  task automatic offer_random(input int radius, input int clear_pct);
    logic signed [COORD_W-1:0] rim_vals [4];
    int pick;
    int k;
    rim_vals = '{COORD_MIN, COORD_MAX, 16'sd0, -16'sd1};
    pick = $urandom_range(99);
    if (pick < clear_pct) begin
      clear_store();
    end else if (pick < 72 && sb.held_count != 0) begin
      k = $urandom_range(sb.held_count - 1);
      send_item(OP_OFFER, nudge(sb.held_x[k], radius), nudge(sb.held_y[k], radius),
                nudge(sb.held_z[k], radius));
    end else if (pick < 80) begin
      send_item(OP_OFFER, rim_vals[$urandom_range(3)], rim_vals[$urandom_range(3)],
                rim_vals[$urandom_range(3)]);
    end else begin
      send_item(OP_OFFER, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  initial begin
    int random_items;
    int phase;
    int radius;
    int clear_pct;
    int item_count;
    bit fill_phase;
    logic [MIN_DIST_W-1:0] min_dist;

    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: collection is off, so offers are refused; a clear works regardless.
    send_item(OP_OFFER, 16'sd0, 16'sd0, 16'sd0);
    clear_store();
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, 34'h1_2345_6789);
    // Only bit zero of the enable register counts.
    write_reg(REG_COLLECT_ENABLE, 34'h3_FFFF_FFFF);

    // Reset spacing: any sample goes into an empty store, then the reset minimum applies.
    send_item(OP_OFFER, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_OFFER, 16'sd100, 16'sd100, 16'sd0);
    send_item(OP_OFFER, 16'sd176, 16'sd0, 16'sd0);
    clear_store();

    write_reg(REG_MIN_DIST, 34'd100);
    send_item(OP_OFFER, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_OFFER, 16'sd6, 16'sd8, 16'sd0);
    send_item(OP_OFFER, 16'sd0, 16'sd0, 16'sd9);
    send_item(OP_OFFER, COORD_MIN, COORD_MIN, COORD_MIN);
    send_item(OP_OFFER, COORD_MAX, COORD_MAX, COORD_MAX);
    clear_store();

    // Opposite corners are exactly the minimum apart and must both be kept.
    write_reg(REG_MIN_DIST, CORNER_SPAN_SQ);
    send_item(OP_OFFER, COORD_MIN, COORD_MIN, COORD_MIN);
    send_item(OP_OFFER, COORD_MAX, COORD_MAX, COORD_MAX);
    send_item(OP_OFFER, 16'sd0, 16'sd0, 16'sd0);
    clear_store();

    write_reg(REG_MIN_DIST, '1);
    send_item(OP_OFFER, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_OFFER, COORD_MIN, COORD_MAX, COORD_MIN);
    clear_store();

    // With a zero minimum even a repeated sample is kept.
    write_reg(REG_MIN_DIST, '0);
    send_item(OP_OFFER, 16'sd5, 16'sd5, 16'sd5);
    send_item(OP_OFFER, 16'sd5, 16'sd5, 16'sd5);
    clear_store();

    random_items = 0;
    phase = 0;
    while (random_items < 1700) begin
      fill_phase = (phase % 5 == 3);
      clear_pct = $urandom_range(1) ? 8 : 3;
      case ($urandom_range(4))
        0: radius = 0;
        1: radius = $urandom_range(1, 64);
        2: radius = $urandom_range(100, 3000);
        default: radius = $urandom_range(8000, 30000);
      endcase
      min_dist = MIN_DIST_W'(longint'(radius) * radius + ($urandom_range(1) ? 0 : 2));
      if ($urandom_range(7) == 0) min_dist = $urandom_range(1) ? '1 : MIN_DIST_W'({$urandom, $urandom});
      if (fill_phase) begin
        radius = 0;
        min_dist = '0;
        clear_pct = 0;
      end
      write_reg(REG_COLLECT_ENABLE, (fill_phase || $urandom_range(9) != 0) ? 34'd1 : 34'd0);
      write_reg(REG_MIN_DIST, min_dist);
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, MIN_DIST_W'({$urandom, $urandom}));
      set_idling(idle_mode_t'(phase % 4));
      // Early on the receiver holds off while offers keep coming, so the block backs up.
      if (phase == 0) recv_hold_req = 400;
      item_count = fill_phase ? 300 : 150;
      for (int i = 0; i < item_count; i++) offer_random(radius, clear_pct);
      random_items += item_count;
      if (fill_phase) begin
        // A full store that is also disabled must report disabled.
        write_reg(REG_COLLECT_ENABLE, 34'd0);
        send_item(OP_OFFER, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      end
      drain_results();
      phase++;
    end

    drain_results();
    repeat (280) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("** spaced_sample_collector: PASSED **");
    end else begin
      $display("** spaced_sample_collector: FAILED **");
    end
    $finish;
  end

endmodule
